/* design/dqn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dqn_pkg
// Shared constants and control/status types for the DNS question encoder.
// ----------------------------------------------------------------------------
package dqn_pkg;

   localparam int MAX_LABEL     = 63;
   localparam int CHAR_W        = 8;
   localparam int LEN_W         = 6;
   localparam int BIDX_W        = 7;   // byte index within one flush, up to 68
   localparam int CFG_W         = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int RSP_DATA_W    = 24;
   localparam int CNT_W         = 2;

   localparam logic [CHAR_W-1:0]    DOT_CHAR      = 8'h2E;
   localparam logic [CHAR_W-1:0]    END_CHAR      = 8'h00;
   localparam logic [CSR_IDX_W-1:0] CSR_QTYPE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_QCLASS    = 1'b1;
   localparam logic [CFG_W-1:0]     CFG_RESET_VAL = 16'h0001;
   localparam logic [BIDX_W-1:0]    TRAILER_BYTES = 7'd5;

   typedef struct packed {
      logic char_wr;       // store a label character
      logic flush_start;   // terminator accepted, latch label and clear counters
      logic issue;         // generate one byte pair, read label store
      logic out_load;      // move pair stage into output register
   } cmd_type;

   typedef struct packed {
      logic is_term;       // incoming word is a dot or the end byte
      logic issue_last;    // pair being issued is the last of this flush
   } sts_type;

endpackage
`default_nettype wire

/* design/dqn_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dqn_ctrl
// Controller: accept/flush state machine and valid tracking for the pair
// stage and the output register.
// ----------------------------------------------------------------------------
module dqn_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire dqn_pkg::sts_type sts,
   output dqn_pkg::cmd_type      cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_FLUSH = 1'b1;

   logic state_ff, state_in;
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic accept, out_free, s1_move, s1_free;

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = out_valid_ff;
      accept     = req_tvalid && req_tready;
      out_free   = !out_valid_ff || rsp_tready;
      s1_move    = s1_valid_ff && out_free;
      s1_free    = !s1_valid_ff || out_free;

      cmd.char_wr     = accept && !sts.is_term;
      cmd.flush_start = accept && sts.is_term;
      cmd.issue       = (state_ff == ST_FLUSH) && s1_free;
      cmd.out_load    = s1_move;

      if (cmd.issue) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.flush_start) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (cmd.issue && sts.issue_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTH
   a_last_issue_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.issue && sts.issue_last |=> state_ff == ST_IDLE)
      else $error("flush did not end after last pair");
   a_flush_enter: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_start |=> state_ff == ST_FLUSH)
      else $error("terminator did not start a flush");
   a_pair_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("pair stage lost while output stalled");
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff)
      else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

/* design/dqn_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dqn_datapath
// Datapath: label store, label counters, query registers, byte pair
// generation and output register.
// ----------------------------------------------------------------------------
module dqn_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [dqn_pkg::CHAR_W-1:0]          req_tdata,
   input  wire logic                                csr_we,
   input  wire logic [dqn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [dqn_pkg::CFG_W-1:0]           csr_wdata,
   input  wire dqn_pkg::cmd_type                    cmd,
   output dqn_pkg::sts_type                         sts,
   output logic [dqn_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                     rsp_tlast,
   output logic [0:0]                               rsp_tuser
);

   logic [dqn_pkg::CHAR_W-1:0] label_mem [0:dqn_pkg::MAX_LABEL-1];

   logic [dqn_pkg::LEN_W-1:0]  label_length_ff, stored_count_ff;
   logic [dqn_pkg::CFG_W-1:0]  qtype_ff, qclass_ff;
   logic [dqn_pkg::LEN_W-1:0]  flen_ff;
   logic                       fzero_ff;
   logic [dqn_pkg::BIDX_W-1:0] j_ff;

   logic                       s1_mem0_ff, s1_mem1_ff;
   logic [dqn_pkg::CHAR_W-1:0] s1_val0_ff, s1_val1_ff, s1_rd0_ff, s1_rd1_ff;
   logic                       s1_two_ff, s1_last_ff, s1_done_ff;

   logic [dqn_pkg::CHAR_W-1:0] out_first_ff, out_second_ff;
   logic [dqn_pkg::CNT_W-1:0]  out_count_ff;
   logic                       out_last_ff, out_done_ff;

   logic [dqn_pkg::BIDX_W-1:0] n_bytes, j1, flen_ext, a0, a1;
   logic                       two, mem0, mem1;
   logic [dqn_pkg::CHAR_W-1:0] val0, val1, pair0, pair1;

   function automatic logic [7:0] fixed_byte(input logic [6:0] j, input logic [5:0] flen,
                                             input logic [15:0] qt, input logic [15:0] qc);
      logic [6:0] t;
      logic [7:0] b;
      t = j - {1'b0, flen} - 7'd1;
      case (t)
         7'd1:    b = qt[15:8];
         7'd2:    b = qt[7:0];
         7'd3:    b = qc[15:8];
         7'd4:    b = qc[7:0];
         default: b = 8'h00;
      endcase
      if (j == 7'd0) b = {2'b00, flen};
      return b;
   endfunction

   always_comb begin
      flen_ext = {1'b0, flen_ff};
      n_bytes  = 7'd1 + flen_ext + (fzero_ff ? dqn_pkg::TRAILER_BYTES : 7'd0);
      j1       = j_ff + 7'd1;
      two      = j1 < n_bytes;
      sts.issue_last = (j_ff + 7'd2) >= n_bytes;
      sts.is_term    = (req_tdata == dqn_pkg::DOT_CHAR) || (req_tdata == dqn_pkg::END_CHAR);
      mem0     = (j_ff != 7'd0) && (j_ff <= flen_ext);
      mem1     = j1 <= flen_ext;
      val0     = fixed_byte(j_ff, flen_ff, qtype_ff, qclass_ff);
      val1     = fixed_byte(j1, flen_ff, qtype_ff, qclass_ff);
      a0       = j_ff - 7'd1;
      a1       = j_ff;
      pair0    = s1_mem0_ff ? s1_rd0_ff : s1_val0_ff;
      pair1    = s1_two_ff ? (s1_mem1_ff ? s1_rd1_ff : s1_val1_ff) : 8'h00;
      rsp_tdata    = {6'd0, out_count_ff, out_second_ff, out_first_ff};
      rsp_tlast    = out_last_ff;
      rsp_tuser[0] = out_done_ff;
   end

   // label store: one write port, two read ports with registered data
   always_ff @(posedge clock) begin
      if (cmd.char_wr && (stored_count_ff < dqn_pkg::LEN_W'(dqn_pkg::MAX_LABEL))) begin
         label_mem[stored_count_ff] <= req_tdata;
      end
      if (cmd.issue) begin
         s1_rd0_ff <= (a0 < 7'(dqn_pkg::MAX_LABEL)) ? label_mem[a0[dqn_pkg::LEN_W-1:0]] : 8'h00;
         s1_rd1_ff <= (a1 < 7'(dqn_pkg::MAX_LABEL)) ? label_mem[a1[dqn_pkg::LEN_W-1:0]] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_length_ff <= '0;
         stored_count_ff <= '0;
         qtype_ff        <= dqn_pkg::CFG_RESET_VAL;
         qclass_ff       <= dqn_pkg::CFG_RESET_VAL;
         flen_ff         <= '0;
         fzero_ff        <= 1'b0;
         j_ff            <= '0;
      end else begin
         if (csr_we && (csr_index == dqn_pkg::CSR_QTYPE))  qtype_ff  <= csr_wdata;
         if (csr_we && (csr_index == dqn_pkg::CSR_QCLASS)) qclass_ff <= csr_wdata;
         if (cmd.char_wr) begin
            label_length_ff <= label_length_ff + 6'd1;
            if (stored_count_ff < dqn_pkg::LEN_W'(dqn_pkg::MAX_LABEL)) begin
               stored_count_ff <= stored_count_ff + 6'd1;
            end
         end
         if (cmd.flush_start) begin
            flen_ff         <= label_length_ff;
            fzero_ff        <= (req_tdata == dqn_pkg::END_CHAR);
            j_ff            <= '0;
            label_length_ff <= '0;
            stored_count_ff <= '0;
         end
         if (cmd.issue) j_ff <= j_ff + 7'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_mem0_ff <= mem0;
         s1_mem1_ff <= mem1;
         s1_val0_ff <= val0;
         s1_val1_ff <= val1;
         s1_two_ff  <= two;
         s1_last_ff <= sts.issue_last;
         s1_done_ff <= sts.issue_last && fzero_ff;
      end
      if (cmd.out_load) begin
         out_first_ff  <= pair0;
         out_second_ff <= pair1;
         out_count_ff  <= s1_two_ff ? 2'd2 : 2'd1;
         out_last_ff   <= s1_last_ff;
         out_done_ff   <= s1_done_ff;
      end
   end

`ifndef SYNTH
   a_len_sat: assert property (@(posedge clock) disable iff (reset)
      stored_count_ff <= dqn_pkg::LEN_W'(dqn_pkg::MAX_LABEL))
      else $error("stored count past label store depth");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_start |=> label_length_ff == '0 && stored_count_ff == '0 && j_ff == '0)
      else $error("label not cleared at terminator");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      cmd.issue && !sts.issue_last |=> !s1_last_ff && !s1_done_ff)
      else $error("early end marker");
`endif

endmodule
`default_nettype wire

/* design/dns_question_name_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dns_question_name_encoder
// Encodes a dotted hostname into a DNS question section, two bytes a word.
// ----------------------------------------------------------------------------
// Label characters: one word per cycle while not flushing, no result.
// Dot or end byte: input held off until ceil(n/2) words are issued, n = 1 + label length
//   (+5 for the end byte); one result word per cycle from the pair generator while not stalled.
// First result passes the flush state, pair stage and output register after the terminator.
// Reset (synchronous): counters cleared, type and class back to 1;
//   the label store is not cleared and needs no clearing pass.
module dns_question_name_encoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [dqn_pkg::CHAR_W-1:0]          req_tdata,   // [7:0] name_char
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] first_byte, [15:8] second_byte, [17:16] byte_count, rest zero
   output logic [dqn_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                     rsp_tlast,   // run_last
   output logic [0:0]                               rsp_tuser,   // [0] question_done
   input  wire logic                                csr_we,
   input  wire logic [dqn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [dqn_pkg::CFG_W-1:0]           csr_wdata
);

   dqn_pkg::cmd_type cmd;
   dqn_pkg::sts_type sts;

   dqn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dqn_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule
`default_nettype wire
